// File: rtl/dxtd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_pkg
// shared types, codes and constant dividers for the dxt block texel decoder
// ----------------------------------------------------------------------------
package dxtd_pkg;

    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned ADDR_W      = 24;
    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [3:0] LAST_TEXEL   = 4'd15;
    localparam logic [1:0] PUNCH_INDEX  = 2'd3;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // reciprocal constants, ceil(2^20 / d), exact for the sums used here
    localparam int unsigned RECIP_SHIFT = 20;
    localparam logic [18:0] RECIP_3     = 19'd349526;
    localparam logic [18:0] RECIP_5     = 19'd209716;
    localparam logic [18:0] RECIP_7     = 19'd149797;

    typedef enum logic [1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2
    } fmt_t;

    typedef struct packed {
        fmt_t                  mode;
        logic [CFG_DATA_W-1:0] width_blocks;
        logic [CFG_DATA_W-1:0] height_blocks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    // one classified block as it waits between front and back
    typedef struct packed {
        colour_t [3:0]     palette;
        logic              punch_through;
        logic [7:0][7:0]   alpha_level;
        fmt_t              mode;
        logic [31:0]       color_index;
        logic [63:0]       alpha_word;
        logic [ADDR_W-1:0] base_address;
        logic [ADDR_W-1:0] row_stride;
        logic              image_last;
    } block_t;

    function automatic logic [7:0] div3(input logic [10:0] n);
        logic [29:0] p;
        begin
            p = 30'(n) * 30'(RECIP_3);
            return p[RECIP_SHIFT +: 8];
        end
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] n);
        logic [29:0] p;
        begin
            p = 30'(n) * 30'(RECIP_5);
            return p[RECIP_SHIFT +: 8];
        end
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] n);
        logic [29:0] p;
        begin
            p = 30'(n) * 30'(RECIP_7);
            return p[RECIP_SHIFT +: 8];
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/dxt_block_texel_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dxt_block_texel_decoder
// s3tc block decoder: one compressed 4x4 block in, sixteen texels out
// ----------------------------------------------------------------------------
//  channel   direction  handshake              transaction
//  in        sink       in_valid / in_ready    one compressed block
//  out       source     out_valid / out_ready  one decoded texel with address
//  cfg       sink       cfg_write              one register write, no stall
//
//  the back-end texel sequencer emits one texel per cycle while out is not
//  stalled and a block waits, so the output register sets the rate
//  first texel of a block shows on out once the block is accepted, by way of
//  the queue write, then the output register load
//  a two-block queue parts the front from the back; in_ready drops only when
//  both entries hold blocks whose last texel has not yet reached the output
//  register
//  reset clears block position, queue pointers and output valid; no sweep
//  an out stall holds the texel and its address in the output register
// ----------------------------------------------------------------------------
module dxt_block_texel_decoder #(
    parameter int unsigned MAX_BLOCKS_PER_SIDE = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [dxtd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dxtd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // compressed blocks
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [15:0]                         endpoint_first,
    input  logic [15:0]                         endpoint_second,
    input  logic [31:0]                         color_index_word,
    input  logic [63:0]                         alpha_word,
    // texels
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          red_value,
    output logic [7:0]                          green_value,
    output logic [7:0]                          blue_value,
    output logic [7:0]                          alpha_value,
    output logic [dxtd_pkg::ADDR_W-1:0]         pixel_address,
    output logic                                block_done,
    output logic                                image_done
);

    dxtd_pkg::cfg_t   cfg_reg;
    dxtd_pkg::cfg_t   cfg_next;
    logic             push;
    dxtd_pkg::block_t push_block;
    logic             queue_full;
    logic             queue_empty;
    logic             pop;
    dxtd_pkg::block_t head_block;

    // configuration registers; writes never touch the block position
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                dxtd_pkg::CFG_FORMAT: cfg_next.mode          = dxtd_pkg::fmt_t'(cfg_data[1:0]);
                dxtd_pkg::CFG_WIDTH:  cfg_next.width_blocks  = cfg_data;
                dxtd_pkg::CFG_HEIGHT: cfg_next.height_blocks = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= dxtd_pkg::FMT_DXT1;
            cfg_reg.width_blocks  <= dxtd_pkg::CFG_DATA_W'(1);
            cfg_reg.height_blocks <= dxtd_pkg::CFG_DATA_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: block acceptance, palette and alpha table, raster position
    dxtd_front #(
        .MAX_BLOCKS_PER_SIDE (MAX_BLOCKS_PER_SIDE)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .endpoint_first   (endpoint_first),
        .endpoint_second  (endpoint_second),
        .color_index_word (color_index_word),
        .alpha_word       (alpha_word),
        .cfg              (cfg_reg),
        .push             (push),
        .push_block       (push_block),
        .queue_full       (queue_full)
    );

    // two classified blocks in flight
    dxtd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_block (push_block),
        .full       (queue_full),
        .pop        (pop),
        .head_block (head_block),
        .empty      (queue_empty)
    );

    // back: texel sequencer and output register
    dxtd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (!queue_empty),
        .head_block    (head_block),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_value     (red_value),
        .green_value   (green_value),
        .blue_value    (blue_value),
        .alpha_value   (alpha_value),
        .pixel_address (pixel_address),
        .block_done    (block_done),
        .image_done    (image_done)
    );

endmodule
`default_nettype wire

// File: rtl/dxtd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_front
// accepts compressed blocks, builds palette and alpha levels, tracks position
// ----------------------------------------------------------------------------
module dxtd_front #(
    parameter int unsigned MAX_BLOCKS_PER_SIDE = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          endpoint_first,
    input  logic [15:0]          endpoint_second,
    input  logic [31:0]          color_index_word,
    input  logic [63:0]          alpha_word,
    input  dxtd_pkg::cfg_t       cfg,
    output logic                 push,
    output dxtd_pkg::block_t     push_block,
    input  logic                 queue_full
);

    localparam int unsigned SIDE_W = $clog2(MAX_BLOCKS_PER_SIDE + 1);
    localparam int unsigned CNT_W  = (MAX_BLOCKS_PER_SIDE > 1) ? $clog2(MAX_BLOCKS_PER_SIDE) : 1;
    localparam int unsigned CMP_W  = (SIDE_W > dxtd_pkg::CFG_DATA_W) ? SIDE_W
                                                                      : dxtd_pkg::CFG_DATA_W;
    localparam int unsigned PROD_W = CNT_W + SIDE_W + 4;

    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  col_next;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  row_next;
    logic [SIDE_W-1:0] width_eff;
    logic [SIDE_W-1:0] height_eff;
    logic              last_col;
    logic              last_row;
    logic              accept;
    logic [PROD_W-1:0] base_full;
    dxtd_pkg::colour_t c0;
    dxtd_pkg::colour_t c1;
    logic              four_colour;
    logic [7:0]        a0;
    logic [7:0]        a1;

    function automatic logic [SIDE_W-1:0] eff_size(input logic [dxtd_pkg::CFG_DATA_W-1:0] v);
        begin
            if (v == '0)
                return SIDE_W'(1);
            else if (CMP_W'(v) > CMP_W'(MAX_BLOCKS_PER_SIDE))
                return SIDE_W'(MAX_BLOCKS_PER_SIDE);
            else
                return SIDE_W'(v);
        end
    endfunction

    function automatic logic [7:0] mix_third(input logic [7:0] a, input logic [7:0] b);
        begin
            return dxtd_pkg::div3({2'b00, a, 1'b0} + {3'b000, b});
        end
    endfunction

    function automatic logic [7:0] mix_half(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[8:1];
        end
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept;

    // position of this block and wrap decisions
    always_comb
    begin
        width_eff  = eff_size(cfg.width_blocks);
        height_eff = eff_size(cfg.height_blocks);
        last_col   = ((SIDE_W + 1)'(col_reg) + (SIDE_W + 1)'(1)) >= (SIDE_W + 1)'(width_eff);
        last_row   = ((SIDE_W + 1)'(row_reg) + (SIDE_W + 1)'(1)) >= (SIDE_W + 1)'(height_eff);
        col_next   = col_reg;
        row_next   = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                    row_next = '0;
                else
                    row_next = CNT_W'(row_reg + 1'b1);
            end
            else
            begin
                col_next = CNT_W'(col_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // palette, alpha levels and addressing for the queue entry
    always_comb
    begin
        c0.red      = {endpoint_first[15:11], 3'b000};
        c0.green    = {endpoint_first[10:5], 2'b00};
        c0.blue     = {endpoint_first[4:0], 3'b000};
        c1.red      = {endpoint_second[15:11], 3'b000};
        c1.green    = {endpoint_second[10:5], 2'b00};
        c1.blue     = {endpoint_second[4:0], 3'b000};
        four_colour = (cfg.mode != dxtd_pkg::FMT_DXT1) || (endpoint_first > endpoint_second);
        a0          = alpha_word[7:0];
        a1          = alpha_word[15:8];

        push_block.palette[0] = c0;
        push_block.palette[1] = c1;
        if (four_colour)
        begin
            push_block.palette[2].red   = mix_third(c0.red, c1.red);
            push_block.palette[2].green = mix_third(c0.green, c1.green);
            push_block.palette[2].blue  = mix_third(c0.blue, c1.blue);
            push_block.palette[3].red   = mix_third(c1.red, c0.red);
            push_block.palette[3].green = mix_third(c1.green, c0.green);
            push_block.palette[3].blue  = mix_third(c1.blue, c0.blue);
        end
        else
        begin
            push_block.palette[2].red   = mix_half(c0.red, c1.red);
            push_block.palette[2].green = mix_half(c0.green, c1.green);
            push_block.palette[2].blue  = mix_half(c0.blue, c1.blue);
            push_block.palette[3]       = '0;
        end
        push_block.punch_through = !four_colour;

        push_block.alpha_level[0] = a0;
        push_block.alpha_level[1] = a1;
        if (a0 > a1)
        begin
            for (int z = 0; z < 6; z++)
                push_block.alpha_level[z + 2] =
                    dxtd_pkg::div7(11'(a0) * 11'(6 - z) + 11'(a1) * 11'(z + 1));
        end
        else
        begin
            for (int z = 0; z < 4; z++)
                push_block.alpha_level[z + 2] =
                    dxtd_pkg::div5(11'(a0) * 11'(4 - z) + 11'(a1) * 11'(z + 1));
            push_block.alpha_level[6] = dxtd_pkg::ALPHA_CLEAR;
            push_block.alpha_level[7] = dxtd_pkg::ALPHA_OPAQUE;
        end

        // top-left pixel: col * 4 + row * 4 * (4 * width)
        base_full = ((PROD_W'(row_reg) * PROD_W'(width_eff)) << 4) + (PROD_W'(col_reg) << 2);

        push_block.mode         = cfg.mode;
        push_block.color_index  = color_index_word;
        push_block.alpha_word   = alpha_word;
        push_block.base_address = dxtd_pkg::ADDR_W'(base_full);
        push_block.row_stride   = dxtd_pkg::ADDR_W'({width_eff, 2'b00});
        push_block.image_last   = last_col && last_row;
    end

endmodule
`default_nettype wire

// File: rtl/dxtd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_queue
// short fifo of classified blocks between front and back
// ----------------------------------------------------------------------------
module dxtd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dxtd_pkg::block_t push_block,
    output logic             full,
    input  logic             pop,
    output dxtd_pkg::block_t head_block,
    output logic             empty
);

    localparam int unsigned PTR_W = $clog2(dxtd_pkg::QUEUE_DEPTH);

    dxtd_pkg::block_t entry_reg [dxtd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full       = count_reg == (PTR_W + 1)'(dxtd_pkg::QUEUE_DEPTH);
    assign empty      = count_reg == '0;
    assign head_block = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = (PTR_W + 1)'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = (PTR_W + 1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_block;
    end

endmodule
`default_nettype wire

// File: rtl/dxtd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_back
// walks the sixteen texels of the head block into the output register
// ----------------------------------------------------------------------------
module dxtd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  dxtd_pkg::block_t            head_block,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  red_value,
    output logic [7:0]                  green_value,
    output logic [7:0]                  blue_value,
    output logic [7:0]                  alpha_value,
    output logic [dxtd_pkg::ADDR_W-1:0] pixel_address,
    output logic                        block_done,
    output logic                        image_done
);

    logic [3:0]                  tex_reg;
    logic [3:0]                  tex_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        advance;
    logic [1:0]                  ci;
    logic [31:0]                 ci_shift;
    logic [63:0]                 nib_shift;
    logic [63:0]                 lvl_shift;
    logic [6:0]                  lvl_pos;
    dxtd_pkg::colour_t           colour;
    logic [7:0]                  alpha;
    logic [dxtd_pkg::ADDR_W-1:0] addr;
    logic [7:0]                  red_reg;
    logic [7:0]                  green_reg;
    logic [7:0]                  blue_reg;
    logic [7:0]                  alpha_reg;
    logic [dxtd_pkg::ADDR_W-1:0] addr_reg;
    logic                        block_done_reg;
    logic                        image_done_reg;

    assign advance = head_valid && (!out_valid_reg || out_ready);
    assign pop     = advance && (tex_reg == dxtd_pkg::LAST_TEXEL);

    always_comb
    begin
        ci_shift  = head_block.color_index >> {tex_reg, 1'b0};
        ci        = ci_shift[1:0];
        colour    = head_block.palette[ci];
        nib_shift = head_block.alpha_word >> {tex_reg, 2'b00};
        lvl_pos   = 7'd16 + 7'({tex_reg, 1'b0}) + 7'(tex_reg);
        lvl_shift = head_block.alpha_word >> lvl_pos;
        case (head_block.mode)
            dxtd_pkg::FMT_DXT1:
                alpha = (head_block.punch_through && ci == dxtd_pkg::PUNCH_INDEX)
                        ? dxtd_pkg::ALPHA_CLEAR : dxtd_pkg::ALPHA_OPAQUE;
            dxtd_pkg::FMT_DXT3:
                alpha = {nib_shift[3:0], 4'b0000};
            default:
                alpha = head_block.alpha_level[lvl_shift[2:0]];
        endcase
        addr = head_block.base_address + dxtd_pkg::ADDR_W'(tex_reg[1:0])
             + (tex_reg[2] ? head_block.row_stride : '0)
             + (tex_reg[3] ? {head_block.row_stride[dxtd_pkg::ADDR_W-2:0], 1'b0} : '0);

        tex_next       = advance ? 4'(tex_reg + 1'b1) : tex_reg;
        out_valid_next = advance || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tex_reg       <= tex_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg        <= colour.red;
            green_reg      <= colour.green;
            blue_reg       <= colour.blue;
            alpha_reg      <= alpha;
            addr_reg       <= addr;
            block_done_reg <= tex_reg == dxtd_pkg::LAST_TEXEL;
            image_done_reg <= (tex_reg == dxtd_pkg::LAST_TEXEL) && head_block.image_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_value     = red_reg;
    assign green_value   = green_reg;
    assign blue_value    = blue_reg;
    assign alpha_value   = alpha_reg;
    assign pixel_address = addr_reg;
    assign block_done    = block_done_reg;
    assign image_done    = image_done_reg;

endmodule
`default_nettype wire

// File: rtl/dxtd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dxtd_checker
// port-level checks on the texel stream, bound to the decoder top level
// ----------------------------------------------------------------------------
module dxtd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [7:0]                  red_value,
    input logic [7:0]                  green_value,
    input logic [7:0]                  blue_value,
    input logic [7:0]                  alpha_value,
    input logic [dxtd_pkg::ADDR_W-1:0] pixel_address,
    input logic                        block_done,
    input logic                        image_done
);

    // a stalled texel stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_value) && $stable(green_value)
            && $stable(blue_value) && $stable(alpha_value) && $stable(pixel_address)
            && $stable(block_done) && $stable(image_done))
        else $error("stalled texel changed");

    // image end only on a block end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> block_done)
        else $error("image_done without block_done");

    // block end is the bottom-right texel, column three of the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_done |-> pixel_address[1:0] == 2'b11)
        else $error("block_done off the last column");

    // texels inside a block row run on by one pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && pixel_address[1:0] != 2'b11) ##1 out_valid
            |-> pixel_address == $past(pixel_address) + 1'b1)
        else $error("texel address not consecutive within a row");

endmodule

bind dxt_block_texel_decoder dxtd_checker u_dxtd_checker (.*);
`default_nettype wire

// File: verif/dxt_block_texel_decoder_test.sv
// ----------------------------------------------------------------------------
// dxt_block_texel_decoder_test
// self-checking bench for the s3tc block texel decoder: compressed blocks go
// in over a valid/ready channel, a behavioural decoder in the scoreboard
// predicts all sixteen texels per block (colour, alpha, address, flags) and
// every texel transaction is checked in order against it
// ----------------------------------------------------------------------------
module dxt_block_texel_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_SIDE       = 1024;
    localparam int unsigned IDLE_PERCENT   = 28;
    localparam int unsigned SETTLE_CYCLES  = 8;     // output register plus queue slack
    localparam int unsigned HOLD_OFF       = 300;   // long receiver stall
    localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles without any transaction
    localparam int unsigned RANDOM_PHASES  = 9;
    localparam int unsigned PHASE_BLOCKS   = 26;

    // index past the register list, must be ignored by the block
    localparam logic [dxtd_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
        logic [7:0]                  alpha;
        logic [dxtd_pkg::ADDR_W-1:0] address;
        logic                        last_of_block;
        logic                        last_of_image;
    } texel_t;

    // ------------------------------------------------------------------------
    // scoreboard: behavioural block decoder plus the queue of texels it owes
    // ------------------------------------------------------------------------
    class texel_scoreboard;
        logic [1:0]  mode_code;
        logic [10:0] width_blocks;
        logic [10:0] height_blocks;
        int unsigned block_col;
        int unsigned block_row;
        texel_t      pending_texels[$];
        int unsigned errors;
        int unsigned texels_checked;

        function new();
            mode_code      = dxtd_pkg::FMT_DXT1;
            width_blocks   = 11'd1;
            height_blocks  = 11'd1;
            block_col      = 0;
            block_row      = 0;
            errors         = 0;
            texels_checked = 0;
        endfunction

        function int unsigned effective_size(input logic [10:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_SIDE)
                return MAX_SIDE;
            return v;
        endfunction

        function void write_register(input logic [dxtd_pkg::CFG_INDEX_W-1:0] idx,
                                     input logic [dxtd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dxtd_pkg::CFG_FORMAT: mode_code     = data[1:0];
                dxtd_pkg::CFG_WIDTH:  width_blocks  = data;
                dxtd_pkg::CFG_HEIGHT: height_blocks = data;
                default:    ;
            endcase
        endfunction

        function int unsigned outstanding();
            return pending_texels.size();
        endfunction

        // expands one block into its sixteen texels and moves the block position on
        function void decode_block(input logic [15:0] e0, input logic [15:0] e1,
                                   input logic [31:0] ci, input logic [63:0] aw);
            int unsigned pal [4][4];
            int unsigned lvl [8];
            int unsigned w, h, x, y, a;
            logic [1:0]  sel;
            bit          last_col, last_row;
            texel_t      t;
            w        = effective_size(width_blocks);
            h        = effective_size(height_blocks);
            last_col = (block_col + 1) >= w;
            last_row = (block_row + 1) >= h;

            pal[0][0] = {e0[15:11], 3'b000};
            pal[0][1] = {e0[10:5], 2'b00};
            pal[0][2] = {e0[4:0], 3'b000};
            pal[1][0] = {e1[15:11], 3'b000};
            pal[1][1] = {e1[10:5], 2'b00};
            pal[1][2] = {e1[4:0], 3'b000};
            for (int i = 0; i < 4; i++)
                pal[i][3] = 255;

            // four-colour palette unless dxt1 asks for punch-through
            if (mode_code != dxtd_pkg::FMT_DXT1 || e0 > e1) begin
                for (int c = 0; c < 3; c++) begin
                    pal[2][c] = (2 * pal[0][c] + pal[1][c]) / 3;
                    pal[3][c] = (pal[0][c] + 2 * pal[1][c]) / 3;
                end
            end else begin
                for (int c = 0; c < 3; c++) begin
                    pal[2][c] = (pal[0][c] + pal[1][c]) / 2;
                    pal[3][c] = 0;
                end
                pal[3][3] = 0;
            end

            lvl[0] = aw[7:0];
            lvl[1] = aw[15:8];
            if (lvl[0] > lvl[1]) begin
                for (int z = 0; z < 6; z++)
                    lvl[z + 2] = ((6 - z) * lvl[0] + (z + 1) * lvl[1]) / 7;
            end else begin
                for (int z = 0; z < 4; z++)
                    lvl[z + 2] = ((4 - z) * lvl[0] + (z + 1) * lvl[1]) / 5;
                lvl[6] = 0;
                lvl[7] = 255;
            end

            for (int i = 0; i < 16; i++) begin
                sel = ci[2 * i +: 2];
                if (mode_code == dxtd_pkg::FMT_DXT1)
                    a = pal[sel][3];
                else if (mode_code == dxtd_pkg::FMT_DXT3)
                    a = {aw[4 * i +: 4], 4'b0000};
                else
                    a = lvl[aw[16 + 3 * i +: 3]];
                x = block_col * 4 + (i % 4);
                y = block_row * 4 + (i / 4);
                t.red           = 8'(pal[sel][0]);
                t.green         = 8'(pal[sel][1]);
                t.blue          = 8'(pal[sel][2]);
                t.alpha         = 8'(a);
                t.address       = dxtd_pkg::ADDR_W'(x + y * w * 4);
                t.last_of_block = (i == 15);
                t.last_of_image = (i == 15) && last_col && last_row;
                pending_texels.push_back(t);
            end

            if (last_col) begin
                block_col = 0;
                block_row = last_row ? 0 : block_row + 1;
            end else begin
                block_col = block_col + 1;
            end
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                $display("%0t: texel %s mismatch, expected %0h actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_texel(input texel_t got);
            texel_t want;
            if (pending_texels.size() == 0) begin
                $display("%0t: texel with nothing expected, actual address %0h",
                         $time, got.address);
                errors++;
                return;
            end
            want = pending_texels.pop_front();
            texels_checked++;
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("address", want.address, got.address);
            compare_field("block_done", want.last_of_block, got.last_of_block);
            compare_field("image_done", want.last_of_image, got.last_of_image);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                             clk              = 1'b0;
    logic                             rst_n            = 1'b0;
    logic                             cfg_write        = 1'b0;
    logic [dxtd_pkg::CFG_INDEX_W-1:0] cfg_index        = '0;
    logic [dxtd_pkg::CFG_DATA_W-1:0]  cfg_data         = '0;
    logic                             in_valid         = 1'b0;
    logic                             in_ready;
    logic [15:0]                      endpoint_first   = '0;
    logic [15:0]                      endpoint_second  = '0;
    logic [31:0]                      color_index_word = '0;
    logic [63:0]                      alpha_word       = '0;
    logic                             out_valid;
    logic                             out_ready        = 1'b0;
    logic [7:0]                       red_value;
    logic [7:0]                       green_value;
    logic [7:0]                       blue_value;
    logic [7:0]                       alpha_value;
    logic [dxtd_pkg::ADDR_W-1:0]      pixel_address;
    logic                             block_done;
    logic                             image_done;

    texel_scoreboard texels;

    // traffic shaping knobs, set by the stimulus
    bit          tx_steady      = 1'b0;
    bit          rx_steady      = 1'b0;
    int unsigned rx_hold_cycles = 0;

    int unsigned blocks_accepted = 0;
    int unsigned reg_writes      = 0;
    int unsigned quiet_cycles    = 0;

    dxt_block_texel_decoder #(
        .MAX_BLOCKS_PER_SIDE(MAX_SIDE)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .endpoint_first   (endpoint_first),
        .endpoint_second  (endpoint_second),
        .color_index_word (color_index_word),
        .alpha_word       (alpha_word),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .red_value        (red_value),
        .green_value      (green_value),
        .blue_value       (blue_value),
        .alpha_value      (alpha_value),
        .pixel_address    (pixel_address),
        .block_done       (block_done),
        .image_done       (image_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitor: input transactions feed the predictor before the output side
    // is checked, so a same-edge texel always finds its expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                texels.decode_block(endpoint_first, endpoint_second,
                                    color_index_word, alpha_word);
                blocks_accepted++;
            end
            if (out_valid && out_ready)
                texels.check_texel('{red: red_value, green: green_value,
                                     blue: blue_value, alpha: alpha_value,
                                     address: pixel_address,
                                     last_of_block: block_done,
                                     last_of_image: image_done});
        end
    end

    // watchdog: a stuck handshake ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("dxt_block_texel_decoder verification failed");
            $finish;
        end
    end

    // receiver: random back-pressure, a steady stretch, and a long hold-off
    // counted here so the sender keeps pushing while texels back up
    initial
    begin
        forever begin
            @(negedge clk);
            if (rx_hold_cycles != 0) begin
                out_ready <= 1'b0;
                repeat (rx_hold_cycles - 1) @(negedge clk);
                rx_hold_cycles = 0;
            end else if (rx_steady) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks: each is entered at a falling edge and returns at one
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [dxtd_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [dxtd_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        texels.write_register(idx, data);
        reg_writes++;
    endtask

    // random sender idling, skipped during steady stretches
    task automatic idle_gap();
        while (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_block(input logic [15:0] e0, input logic [15:0] e1,
                              input logic [31:0] ci, input logic [63:0] aw);
        idle_gap();
        in_valid         <= 1'b1;
        endpoint_first   <= e0;
        endpoint_second  <= e1;
        color_index_word <= ci;
        alpha_word       <= aw;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // sender pause: every texel in, then let the pipe settle
    task automatic drain_texels();
        in_valid <= 1'b0;
        while (texels.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly small images so counters wrap often, now and then the clamps
    function automatic logic [10:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return 11'($urandom_range(4, 1));
        if (r < 80)
            return 11'd0;
        if (r < 88)
            return 11'(MAX_SIDE);
        if (r < 94)
            return 11'($urandom_range(2047, MAX_SIDE + 1));
        return 11'($urandom_range(MAX_SIDE - 1, 5));
    endfunction

    task automatic random_phase(input int unsigned n_blocks);
        logic [15:0] e0, e1;
        logic [63:0] aw;
        drain_texels();
        // upper data bits ride along on the format write and must be dropped
        write_register(dxtd_pkg::CFG_FORMAT, 11'($urandom));
        write_register(dxtd_pkg::CFG_WIDTH, pick_size());
        write_register(dxtd_pkg::CFG_HEIGHT, pick_size());
        if ($urandom_range(3) == 0)
            write_register(CFG_SPARE, 11'($urandom));
        repeat (n_blocks) begin
            e0 = 16'($urandom);
            e1 = ($urandom_range(99) < 20) ? e0 : 16'($urandom);
            aw = {$urandom, $urandom};
            // equal alpha endpoints pick the six-level table edge case
            if ($urandom_range(99) < 15)
                aw[15:8] = aw[7:0];
            send_block(e0, e1, $urandom, aw);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        texels = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // dxt1 at reset values, single-block image: four-colour, punch-through
        // and equal endpoints, with every palette index
        send_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 64'h0123456789ABCDEF);
        send_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 64'hFFFFFFFFFFFFFFFF);
        send_block(16'h8410, 16'h8410, 32'hFFFFFFFF, 64'h0);
        send_block(16'hF81F, 16'h07E0, 32'h1B1B1B1B, 64'h0);
        send_block(16'h07E0, 16'hF81F, 32'h00000000, 64'h0);

        // dxt3 on a 3x2 image: every nibble value, counter wrap at both edges
        drain_texels();
        write_register(dxtd_pkg::CFG_FORMAT, 11'(dxtd_pkg::FMT_DXT3));
        write_register(dxtd_pkg::CFG_WIDTH, 11'd3);
        write_register(dxtd_pkg::CFG_HEIGHT, 11'd2);
        send_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 64'hFEDCBA9876543210);
        send_block(16'h1234, 16'hFEDC, 32'h9C9C9C9C, 64'hFFFFFFFFFFFFFFFF);
        send_block(16'hFFFF, 16'hFFFF, 32'hE4E4E4E4, 64'h0000000000000000);
        send_block(16'hAAAA, 16'h5555, 32'h4E4E4E4E, 64'h0123456789ABCDEF);
        send_block(16'h5555, 16'hAAAA, 32'hB1B1B1B1, 64'h5A5A5A5A5A5A5A5A);
        send_block(16'hC618, 16'h39E7, 32'hE4E4E4E4, 64'hA5A5A5A5A5A5A5A5);

        // dxt5: eight-level and six-level tables, equal endpoints, all eight
        // alpha codes; zero width clamps up, oversize height clamps down
        drain_texels();
        write_register(dxtd_pkg::CFG_FORMAT, 11'(dxtd_pkg::FMT_DXT5));
        write_register(dxtd_pkg::CFG_WIDTH, 11'd0);
        write_register(dxtd_pkg::CFG_HEIGHT, 11'h7FF);
        send_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, {48'hFAC688FAC688, 8'h00, 8'hFF});
        send_block(16'h0000, 16'hFFFF, 32'h1B1B1B1B, {48'hFAC688FAC688, 8'hB0, 8'h20});
        send_block(16'h7BEF, 16'h7BEF, 32'hE4E4E4E4, {48'hFAC688FAC688, 8'h80, 8'h80});
        send_block(16'h1F00, 16'h00F8, 32'hFFFFFFFF, {48'hFFFFFFFFFFFF, 8'h00, 8'h00});

        // undefined format code decodes as dxt5, oversize width clamps, and a
        // write to the unused index leaves everything alone
        drain_texels();
        write_register(dxtd_pkg::CFG_FORMAT, 11'h7FF);
        write_register(dxtd_pkg::CFG_WIDTH, 11'd1500);
        write_register(dxtd_pkg::CFG_HEIGHT, 11'd1);
        write_register(CFG_SPARE, 11'h5A5);
        send_block(16'hF800, 16'h001F, 32'hE4E4E4E4, {48'h123456789ABC, 8'h10, 8'hF0});
        send_block(16'h001F, 16'hF800, 32'h39393939, {48'hFEDCBA987654, 8'hF0, 8'h10});

        // shrink the image part way through: counters beyond the new size
        // wrap at the end of the current block
        drain_texels();
        write_register(dxtd_pkg::CFG_WIDTH, 11'd4);
        write_register(dxtd_pkg::CFG_HEIGHT, 11'd3);
        send_block(16'h4208, 16'h2104, 32'hE4E4E4E4, 64'h0F0F0F0F0F0F0F0F);
        send_block(16'h2104, 16'h4208, 32'h1B1B1B1B, 64'hF0F0F0F0F0F0F0F0);
        send_block(16'h8000, 16'h0001, 32'hE4E4E4E4, 64'h3333333333333333);
        send_block(16'h0001, 16'h8000, 32'hE4E4E4E4, 64'hCCCCCCCCCCCCCCCC);
        drain_texels();
        write_register(dxtd_pkg::CFG_WIDTH, 11'd2);
        write_register(dxtd_pkg::CFG_HEIGHT, 11'd1);
        send_block(16'hFFE0, 16'h001F, 32'hE4E4E4E4, 64'h0000FFFF0000FFFF);
        send_block(16'h001F, 16'hFFE0, 32'hE4E4E4E4, 64'hFFFF0000FFFF0000);

        // random phases, each opening with a full drain and new settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            tx_steady = (p == 2) || (p == 5);
            rx_steady = (p == 5);
            // hold-off starts once the pipe is empty so it overlaps sending
            if (p == 2) begin
                drain_texels();
                rx_hold_cycles = HOLD_OFF;
            end
            random_phase(PHASE_BLOCKS);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        drain_texels();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("run covered %0d blocks and %0d texels over %0d register writes,",
                 blocks_accepted, texels.texels_checked, reg_writes);
        $display("all format codes, size clamps, counter wraps, resizes and stalls");
        if (texels.errors == 0 && texels.outstanding() == 0)
            $display("dxt_block_texel_decoder verification clean");
        else
            $display("dxt_block_texel_decoder verification failed");
        $finish;
    end

endmodule

// File: dxt_block_texel_decoder.f
rtl/dxtd_pkg.sv
rtl/dxtd_front.sv
rtl/dxtd_queue.sv
rtl/dxtd_back.sv
rtl/dxt_block_texel_decoder.sv
rtl/dxtd_checker.sv
verif/dxt_block_texel_decoder_test.sv
